/* hdl/egc_pkg.sv */
// ----------------------------------------------------------------------------
// egc_pkg
// Shared types, constants and the servo angle table for the grip classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package egc_pkg;

    // Field widths
    localparam int SampleW = 10;
    localparam int TimeW   = 32;
    localparam int AlphaW  = 16;
    localparam int CalW    = 16;
    localparam int OffsW   = 10;
    localparam int FracW   = 16;
    localparam int FiltW   = SampleW + FracW;
    localparam int AngleW  = 8;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 16;

    // Register reset values
    localparam logic [AlphaW-1:0] AlphaRst = 16'd6554;
    localparam logic [CalW-1:0]   CalRst   = 16'd5000;
    localparam logic [OffsW-1:0]  LowRst   = 10'd10;
    localparam logic [OffsW-1:0]  HighRst  = 10'd50;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_ALPHA = 2'd0,
        CFG_CAL   = 2'd1,
        CFG_LOW   = 2'd2,
        CFG_HIGH  = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_CALIB    = 2'd0,
        PH_FINISHED = 2'd1,
        PH_CLASSIFY = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        GRIP_RELAX = 2'd0,
        GRIP_MILD  = 2'd1,
        GRIP_FULL  = 2'd2
    } grip_t;

    typedef struct packed {
        logic [AngleW-1:0] pinky;
        logic [AngleW-1:0] ring;
        logic [AngleW-1:0] middle;
        logic [AngleW-1:0] index;
        logic [AngleW-1:0] thumb;
    } angles_t;

    // Servo pose for each grip class; thumb stays at home
    function automatic angles_t grip_angles(input grip_t g);
        angles_t a;
        a.thumb = 8'd90;
        case (g)
            GRIP_MILD:
            begin
                a.pinky  = 8'd30;
                a.ring   = 8'd160;
                a.middle = 8'd50;
                a.index  = 8'd180;
            end
            GRIP_FULL:
            begin
                a.pinky  = 8'd100;
                a.ring   = 8'd160;
                a.middle = 8'd50;
                a.index  = 8'd180;
            end
            default:
            begin
                a.pinky  = 8'd30;
                a.ring   = 8'd20;
                a.middle = 8'd160;
                a.index  = 8'd0;
            end
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

/* hdl/egc_if.sv */
// ----------------------------------------------------------------------------
// egc_in_if / egc_out_if
// Valid/ready channels for sensor samples and classifier results.
// ----------------------------------------------------------------------------
`default_nettype none

interface egc_in_if
    import egc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [SampleW-1:0] sample;
    logic [TimeW-1:0]   now_ms;

    modport source (output valid, output sample, output now_ms, input ready);
    modport sink   (input valid, input sample, input now_ms, output ready);
endinterface

interface egc_out_if
    import egc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         phase;
    logic [1:0]         grip;
    logic [SampleW-1:0] smoothed;
    logic [AngleW-1:0]  pinky_angle;
    logic [AngleW-1:0]  ring_angle;
    logic [AngleW-1:0]  middle_angle;
    logic [AngleW-1:0]  index_angle;
    logic [AngleW-1:0]  thumb_angle;

    modport source (output valid, output phase, output grip, output smoothed,
                    output pinky_angle, output ring_angle, output middle_angle,
                    output index_angle, output thumb_angle, input ready);
    modport sink   (input valid, input phase, input grip, input smoothed,
                    input pinky_angle, input ring_angle, input middle_angle,
                    input index_angle, input thumb_angle, output ready);
endinterface

`default_nettype wire

/* hdl/emg_grip_classifier.sv */
// An accepted sample passes the input register, then the result register, to res.
// Throughput: one sample per cycle while res accepts results; the filter
// multiply-add between the input and result registers closes the recurrence.
// Reset: asynchronous, active low; filter, timing and baseline state clear,
// calibration restarts, registers return to their default values.
// ----------------------------------------------------------------------------
// emg_grip_classifier
// EMA-smoothed muscle sensor classifier with start-up baseline calibration.
// ----------------------------------------------------------------------------
`default_nettype none

module emg_grip_classifier
    import egc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data,
    egc_in_if.sink                   samp,
    egc_out_if.source                res
);

    // Configuration registers
    logic [AlphaW-1:0] alpha_reg;
    logic [CalW-1:0]   cal_reg;
    logic [OffsW-1:0]  low_reg;
    logic [OffsW-1:0]  high_reg;

    // Input stage
    logic               s1_valid_reg;
    logic [SampleW-1:0] s1_sample_reg;
    logic [TimeW-1:0]   s1_now_reg;

    // Filter and calibration state
    logic [FiltW-1:0]   filter_reg;
    logic [TimeW-1:0]   start_time_reg;
    logic               start_seen_reg;
    logic               calibrating_reg;
    logic [SampleW-1:0] baseline_reg;

    // Result stage
    logic               out_valid_reg;
    phase_t             phase_reg;
    grip_t              grip_reg;
    logic [SampleW-1:0] smoothed_reg;
    angles_t            angles_reg;

    // Handshake
    logic out_free;
    logic s1_adv;
    logic in_take;

    assign out_free  = !out_valid_reg || res.ready;
    assign s1_adv    = s1_valid_reg && out_free;
    assign samp.ready = !s1_valid_reg || out_free;
    assign in_take   = samp.valid && samp.ready;

    // Filter datapath
    logic [AlphaW:0]          one_minus;
    logic [AlphaW+FiltW:0]    decay_prod;
    logic [FiltW-1:0]         gain_prod;
    logic [FiltW+1:0]         filter_sum;
    logic [FiltW-1:0]         filter_next;
    logic [SampleW-1:0]       sm;

    assign one_minus   = (AlphaW+1)'(1 << AlphaW) - {1'b0, alpha_reg};
    assign decay_prod  = (AlphaW+FiltW+1)'(one_minus) * (AlphaW+FiltW+1)'(filter_reg);
    assign gain_prod   = FiltW'(alpha_reg) * FiltW'(s1_sample_reg);
    assign filter_sum  = (FiltW+2)'(decay_prod[AlphaW+FiltW:FracW]) + (FiltW+2)'(gain_prod);
    assign filter_next = filter_sum[FiltW-1:0];
    assign sm          = filter_next[FiltW-1:FracW];

    // Calibration timing and classification
    logic [TimeW-1:0]   start_eff;
    logic [TimeW-1:0]   elapsed;
    logic               cal_done;
    logic [SampleW:0]   thr_hi;
    logic [SampleW:0]   thr_lo;
    phase_t             phase_next;
    grip_t              grip_next;

    assign start_eff = start_seen_reg ? start_time_reg : s1_now_reg;
    assign elapsed   = s1_now_reg - start_eff;
    assign cal_done  = elapsed >= TimeW'(cal_reg);
    assign thr_hi    = {1'b0, baseline_reg} + (SampleW+1)'(high_reg);
    assign thr_lo    = {1'b0, baseline_reg} + (SampleW+1)'(low_reg);

    always_comb
    begin
        grip_next = GRIP_RELAX;
        if (calibrating_reg)
        begin
            phase_next = cal_done ? PH_FINISHED : PH_CALIB;
        end
        else
        begin
            phase_next = PH_CLASSIFY;
            if ({1'b0, sm} > thr_hi)
            begin
                grip_next = GRIP_FULL;
            end
            else if ({1'b0, sm} > thr_lo)
            begin
                grip_next = GRIP_MILD;
            end
        end
    end

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= AlphaRst;
            cal_reg   <= CalRst;
            low_reg   <= LowRst;
            high_reg  <= HighRst;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ALPHA: alpha_reg <= cfg_data[AlphaW-1:0];
                CFG_CAL:   cal_reg   <= cfg_data[CalW-1:0];
                CFG_LOW:   low_reg   <= cfg_data[OffsW-1:0];
                CFG_HIGH:  high_reg  <= cfg_data[OffsW-1:0];
                default: ;
            endcase
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            filter_reg      <= '0;
            start_time_reg  <= '0;
            start_seen_reg  <= 1'b0;
            calibrating_reg <= 1'b1;
            baseline_reg    <= '0;
        end
        else
        begin
            if (samp.ready)
            begin
                s1_valid_reg <= samp.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_adv)
            begin
                filter_reg     <= filter_next;
                start_seen_reg <= 1'b1;
                if (!start_seen_reg)
                begin
                    start_time_reg <= s1_now_reg;
                end
                if (calibrating_reg && cal_done)
                begin
                    calibrating_reg <= 1'b0;
                    baseline_reg    <= sm;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_sample_reg <= samp.sample;
            s1_now_reg    <= samp.now_ms;
        end
        if (s1_adv)
        begin
            phase_reg    <= phase_next;
            grip_reg     <= grip_next;
            smoothed_reg <= sm;
            angles_reg   <= grip_angles(grip_next);
        end
    end

    // Result channel
    assign res.valid        = out_valid_reg;
    assign res.phase        = phase_reg;
    assign res.grip         = grip_reg;
    assign res.smoothed     = smoothed_reg;
    assign res.pinky_angle  = angles_reg.pinky;
    assign res.ring_angle   = angles_reg.ring;
    assign res.middle_angle = angles_reg.middle;
    assign res.index_angle  = angles_reg.index;
    assign res.thumb_angle  = angles_reg.thumb;

endmodule

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for emg_grip_classifier. A scoreboard class keeps its
// own copy of the low-pass filter, calibration timer and baseline, works out
// the phase, grip class and servo pose for every accepted sample, and checks
// each result transaction against it in order. The bench walks through
// calibration once, then runs classifying phases under many register
// settings, with random idling on both channels and deliberate back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import egc_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int PhaseItems    = 100;
    localparam int PhaseCount    = 12;
    localparam int HoldCycles    = 90;
    localparam logic [TimeW-1:0] FirstStamp = 32'hFFFF_FFF0;

    // One classifier result as seen on the output channel
    typedef struct packed {
        logic [1:0]         phase;
        logic [1:0]         grip;
        logic [SampleW-1:0] smoothed;
        logic [AngleW-1:0]  pinky;
        logic [AngleW-1:0]  ring;
        logic [AngleW-1:0]  middle;
        logic [AngleW-1:0]  index;
        logic [AngleW-1:0]  thumb;
    } grip_report_t;

    // ------------------------------------------------------------------------
    // Scoreboard: filter/calibration predictor plus in-order result check
    // ------------------------------------------------------------------------
    class grip_scoreboard;
        logic [AlphaW-1:0]  alpha;
        logic [CalW-1:0]    cal_len;
        logic [OffsW-1:0]   low_ofs;
        logic [OffsW-1:0]   high_ofs;
        logic [FiltW-1:0]   filt;
        logic [TimeW-1:0]   t_start;
        bit                 started;
        bit                 calibrating;
        logic [SampleW-1:0] baseline;
        grip_report_t       reports_due[$];
        int                 mismatches;
        int                 samples_seen;
        int                 reports_seen;
        int                 grip_tally[3];
        int                 phase_tally[3];

        function new();
            alpha       = AlphaRst;
            cal_len     = CalRst;
            low_ofs     = LowRst;
            high_ofs    = HighRst;
            filt        = '0;
            t_start     = '0;
            started     = 1'b0;
            calibrating = 1'b1;
            baseline    = '0;
            mismatches  = 0;
            samples_seen = 0;
            reports_seen = 0;
            grip_tally  = '{0, 0, 0};
            phase_tally = '{0, 0, 0};
        endfunction

        function int pending();
            return reports_due.size();
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CfgDataW-1:0] d);
            case (idx)
                CFG_ALPHA: alpha    = d[AlphaW-1:0];
                CFG_CAL:   cal_len  = d[CalW-1:0];
                CFG_LOW:   low_ofs  = d[OffsW-1:0];
                CFG_HIGH:  high_ofs = d[OffsW-1:0];
                default: ;
            endcase
        endfunction

        // Servo pose per grip class; thumb always at home
        function void pose(grip_t g, inout grip_report_t r);
            r.thumb = 8'd90;
            case (g)
                GRIP_FULL:
                begin
                    r.pinky = 8'd100; r.ring = 8'd160; r.middle = 8'd50; r.index = 8'd180;
                end
                GRIP_MILD:
                begin
                    r.pinky = 8'd30; r.ring = 8'd160; r.middle = 8'd50; r.index = 8'd180;
                end
                default:
                begin
                    r.pinky = 8'd30; r.ring = 8'd20; r.middle = 8'd160; r.index = 8'd0;
                end
            endcase
        endfunction

        // Advance the filter and timer for one accepted sample
        function void note_sample(logic [SampleW-1:0] s, logic [TimeW-1:0] t);
            logic [63:0]        acc;
            logic [SampleW-1:0] sm;
            logic [TimeW-1:0]   elapsed;
            logic [OffsW:0]     lo_lim;
            logic [OffsW:0]     hi_lim;
            phase_t             ph;
            grip_t              g;
            grip_report_t       r;

            acc  = 64'(alpha) * 64'(s)
                 + (((64'd65536 - 64'(alpha)) * 64'(filt)) >> FracW);
            filt = acc[FiltW-1:0];
            sm   = filt[FiltW-1:FracW];
            g    = GRIP_RELAX;

            if (!started)
            begin
                t_start = t;
                started = 1'b1;
            end

            if (calibrating)
            begin
                elapsed = t - t_start;
                if (elapsed < {16'd0, cal_len})
                    ph = PH_CALIB;
                else
                begin
                    calibrating = 1'b0;
                    baseline    = sm;
                    ph          = PH_FINISHED;
                end
            end
            else
            begin
                // thresholds at 11 bits, full test wins over mild
                hi_lim = {1'b0, baseline} + {1'b0, high_ofs};
                lo_lim = {1'b0, baseline} + {1'b0, low_ofs};
                ph = PH_CLASSIFY;
                if ({1'b0, sm} > hi_lim)
                    g = GRIP_FULL;
                else if ({1'b0, sm} > lo_lim)
                    g = GRIP_MILD;
            end

            r.phase    = ph;
            r.grip     = g;
            r.smoothed = sm;
            pose(g, r);
            reports_due.push_back(r);
            samples_seen++;
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_result(grip_report_t got);
            grip_report_t want;
            bit           bad;

            reports_seen++;
            if (reports_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result phase=%0d grip=%0d smoothed=%0d",
                             got.phase, got.grip, got.smoothed);
                return;
            end
            want = reports_due.pop_front();
            bad = (got.phase !== want.phase) || (got.grip !== want.grip)
                || (got.smoothed !== want.smoothed) || (got.pinky !== want.pinky)
                || (got.ring !== want.ring) || (got.middle !== want.middle)
                || (got.index !== want.index) || (got.thumb !== want.thumb);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: result %0d expected ph=%0d grip=%0d sm=%0d ang=%0d/%0d/%0d/%0d/%0d",
                             reports_seen, want.phase, want.grip, want.smoothed, want.pinky,
                             want.ring, want.middle, want.index, want.thumb);
                    $display("       actual   ph=%0d grip=%0d sm=%0d ang=%0d/%0d/%0d/%0d/%0d",
                             got.phase, got.grip, got.smoothed, got.pinky,
                             got.ring, got.middle, got.index, got.thumb);
                end
            end
            else
            begin
                phase_tally[want.phase]++;
                grip_tally[want.grip]++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    egc_in_if  samp_if ();
    egc_out_if res_if ();

    emg_grip_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samp      (samp_if.sink),
        .res       (res_if.source)
    );

    grip_scoreboard sb;
    int snd_max_gap;
    int rcv_max_gap;
    bit hold_req;
    int cfg_writes;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic [SampleW-1:0] s, input logic [TimeW-1:0] t);
        int gap;
        gap = $urandom_range(0, snd_max_gap);
        if (gap > 0)
        begin
            samp_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samp_if.valid  <= 1'b1;
        samp_if.sample <= s;
        samp_if.now_ms <= t;
        @(posedge clk);
        while (!samp_if.ready) @(posedge clk);
        sb.note_sample(s, t);
    endtask

    // Stop offering and let every outstanding result come back
    task automatic drain_results();
        samp_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] d);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        sb.set_reg(idx, d);
        cfg_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offset mix: extremes, small values near the usual range, anything
    function automatic logic [CfgDataW-1:0] pick_offset();
        logic [OffsW-1:0] o;
        case ($urandom_range(0, 4))
            0:       o = '0;
            1:       o = '1;
            2, 3:    o = OffsW'($urandom_range(0, 60));
            default: o = OffsW'($urandom_range(0, 1023));
        endcase
        return {6'($urandom_range(0, 63)), o};
    endfunction

    // Samples cluster around the live thresholds so every class is hit
    function automatic logic [SampleW-1:0] pick_sample();
        int r;
        int target;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 4)
            return SampleW'($urandom_range(0, 1023));
        target = int'(sb.baseline) + (r < 7 ? int'(sb.low_ofs) : int'(sb.high_ofs))
               + $urandom_range(0, 6) - 3;
        if (target < 0)
            target = 0;
        if (target > 1023)
            target = 1023;
        return SampleW'(target);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random ready gaps, one long hold on request
    // ------------------------------------------------------------------------
    initial
    begin
        int           gap;
        grip_report_t got;
        res_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                res_if.ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                gap = $urandom_range(0, rcv_max_gap);
                if (gap > 0)
                begin
                    res_if.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!res_if.valid) @(posedge clk);
            got.phase    = res_if.phase;
            got.grip     = res_if.grip;
            got.smoothed = res_if.smoothed;
            got.pinky    = res_if.pinky_angle;
            got.ring     = res_if.ring_angle;
            got.middle   = res_if.middle_angle;
            got.index    = res_if.index_angle;
            got.thumb    = res_if.thumb_angle;
            sb.check_result(got);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles without any transaction on either channel
    // ------------------------------------------------------------------------
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WatchdogLimit)
        begin
            @(posedge clk);
            if (!rst_n || (samp_if.valid && samp_if.ready) || (res_if.valid && res_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("ERROR: no transaction for %0d cycles", WatchdogLimit);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [SampleW-1:0] base;
        int                 n;
        sb = new();
        hold_req    = 1'b0;
        snd_max_gap = 17;
        rcv_max_gap = 17;
        cfg_writes  = 0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_ALPHA;
        cfg_data       <= '0;
        samp_if.valid  <= 1'b0;
        samp_if.sample <= '0;
        samp_if.now_ms <= '0;
        @(posedge rst_n);
        @(posedge clk);

        // Calibration at defaults; timestamps wrap past 2^32
        send_sample(10'd1023, FirstStamp);
        send_sample(10'd0, FirstStamp + 32'd100);
        send_sample(10'd512, FirstStamp + 32'd4999);
        drain_results();

        // Longest calibration, fastest filter
        write_reg(CFG_CAL, 16'hFFFF);
        write_reg(CFG_ALPHA, 16'hFFFF);
        send_sample(10'd300, FirstStamp + 32'd65534);
        send_sample(10'd300, FirstStamp + 32'd1);
        drain_results();

        // Zero length: ends on the next sample, elapsed exactly zero
        write_reg(CFG_CAL, 16'd0);
        send_sample(10'd300, FirstStamp);
        base = sb.baseline;
        send_sample(base, $urandom());
        send_sample(10'd1023, $urandom());
        send_sample(10'd0, $urandom());
        send_sample(base + 10'd30, $urandom());
        send_sample(base + 10'd30, $urandom());
        drain_results();

        // Full threshold below the mild one
        write_reg(CFG_LOW, 16'd1023);
        write_reg(CFG_HIGH, 16'd0);
        send_sample(base + 10'd2, $urandom());
        send_sample(base, $urandom());
        send_sample(base, $urandom());
        drain_results();

        // Widest full threshold, no wrap at 11 bits
        write_reg(CFG_LOW, 16'd0);
        write_reg(CFG_HIGH, 16'hFFFF);
        send_sample(10'd1023, $urandom());
        send_sample(10'd1023, $urandom());
        send_sample(base, $urandom());
        drain_results();

        // Frozen filter
        write_reg(CFG_ALPHA, 16'd0);
        send_sample(10'd1023, $urandom());
        send_sample(10'd0, $urandom());
        drain_results();

        // Random phases, each under its own register setting
        for (int ph = 0; ph < PhaseCount; ph++)
        begin
            drain_results();
            case (ph % 4)
                0:       write_reg(CFG_ALPHA, 16'hFFFF);
                1:       write_reg(CFG_ALPHA, 16'd0);
                2:       write_reg(CFG_ALPHA, 16'($urandom_range(0, 65535)));
                default: write_reg(CFG_ALPHA, 16'($urandom_range(2000, 30000)));
            endcase
            write_reg(CFG_CAL, 16'($urandom_range(0, 65535)));
            write_reg(CFG_LOW, pick_offset());
            write_reg(CFG_HIGH, pick_offset());
            snd_max_gap = (ph % 3 == 1) ? 0 : 17;
            rcv_max_gap = (ph % 3 == 2) ? 0 : 17;
            if (ph == 2 || ph == 7)
            begin
                // Back-pressure: results held off while samples keep coming
                snd_max_gap = 0;
                hold_req    = 1'b1;
            end
            for (n = 0; n < PhaseItems; n++)
            begin
                if (ph == 5 && n == PhaseItems / 2)
                    drain_results();
                send_sample(pick_sample(), $urandom());
            end
        end

        drain_results();
        repeat (10) @(posedge clk);

        $display("Run: %0d samples, %0d results, %0d register writes, %0d mismatches",
                 sb.samples_seen, sb.reports_seen, cfg_writes, sb.mismatches);
        $display("Classes matched: relax %0d, mild %0d, full %0d (phases %0d/%0d/%0d)",
                 sb.grip_tally[0], sb.grip_tally[1], sb.grip_tally[2],
                 sb.phase_tally[0], sb.phase_tally[1], sb.phase_tally[2]);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
